// ----- rtl/ghi_pkg.sv -----
// ---------------------------------------------------------------------------
// ghi_pkg
// Shared widths, field positions, register map and constants for the gyro
// heading integrator.
// ---------------------------------------------------------------------------
package ghi_pkg;

  localparam int FRACTION_BITS_DEF = 24;

  // input beat layout
  localparam int TICK_W      = 32;
  localparam int WORD_W      = 16;
  localparam int RATE_W      = 14;
  localparam int ANGLE_W     = 14;
  localparam int TEMP_W      = 12;
  localparam int IN_TDATA_W  = 80;
  localparam int TICK_LSB    = 0;
  localparam int RATE_LSB    = TICK_LSB + TICK_W;
  localparam int ANGLE_LSB   = RATE_LSB + WORD_W;
  localparam int TEMP_LSB    = ANGLE_LSB + WORD_W;

  // output beat layout
  localparam int RATE_OUT_W  = 15;
  localparam int TQ8_W       = 18;
  localparam int HEAD_W      = 23;
  localparam int OUT_PAD_W   = 2;
  localparam int OUT_TDATA_W = RATE_OUT_W + ANGLE_W + TQ8_W + HEAD_W + OUT_PAD_W;

  // datapath
  localparam int ACC_W       = 45;
  localparam int SUM_W       = 47;
  localparam int MA_W        = 46;
  localparam int MB_W        = 17;
  localparam int PROD_W      = MA_W + MB_W;
  localparam int BIAS_W      = 30;
  localparam int TDIFF_W     = 13;
  localparam int TPROD_W     = 26;
  localparam int SCALE_SPLIT = 12;
  localparam int PART_W      = ACC_W + SCALE_SPLIT;
  localparam int TOTAL_W     = PART_W + 1;
  localparam int BIAS_FRAC   = 24;
  localparam int TEMP_SHIFT  = 8;
  localparam int HEAD_SHIFT_EXTRA = 4;

  localparam logic [MB_W-1:0]   TEMP_SCALE  = MB_W'(9522);
  localparam logic [TQ8_W-1:0]  TEMP_OFFSET = TQ8_W'(6400);
  localparam logic [HEAD_W-1:0] HEAD_MAX    = {HEAD_W{1'b1}};

  // configuration registers
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 5;
  localparam int REG_IDX_W    = 3;
  localparam int INIT_TEMP_W  = 12;
  localparam int BIAS_COEF_W  = 16;
  localparam int DEADBAND_W   = 13;
  localparam int WRAP_W       = 21;
  localparam int SCALE_W      = 24;
  localparam int MIN_INT_W    = 8;

  localparam logic [REG_IDX_W-1:0] REG_INIT_TEMP = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BIAS_COEF = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DEADBAND  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WRAP      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SCALE     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MIN_INT   = 3'd5;

  localparam logic [INIT_TEMP_W-1:0] INIT_TEMP_RST = '0;
  localparam logic [BIAS_COEF_W-1:0] BIAS_COEF_RST = BIAS_COEF_W'(12432);
  localparam logic [DEADBAND_W-1:0]  DEADBAND_RST  = DEADBAND_W'(10);
  localparam logic [WRAP_W-1:0]      WRAP_RST      = WRAP_W'(1258065);
  localparam logic [SCALE_W-1:0]     SCALE_RST     = SCALE_W'(48007);
  localparam logic [MIN_INT_W-1:0]   MIN_INT_RST   = MIN_INT_W'(4);

endpackage

// ----- rtl/gyro_heading_integrator_unit.sv -----
// ---------------------------------------------------------------------------
// gyro_heading_integrator_unit
// Gyro rate integration with temperature bias correction, deadband and a
// wrapping heading accumulator, built round one shared multiplier.
// ---------------------------------------------------------------------------
// Usage
//   in_*  : one beat per gyro sample (tick, rate, angle and temperature words).
//           A beat whose tick is less than min_interval after the last taken
//           sample is dropped and gives no output beat.
//   out_* : one beat per taken sample: negated rate, device angle, temperature
//           in Q8 and heading in Q8.
//   psel..: register port; user writes only while the block is idle (unenforced)
// Sequence
//   A taken sample steps the sequencer through bias, delta, deadband, sum,
//   wrap, heading high, heading low and finish (bias, temperature, two halves
//   of the heading product each use the one shared 46x17 multiplier).
//   A dropped sample keeps the sequencer idle. in_tready is high only while idle.
// Reset and stalls
//   rst_n low clears the heading accumulator, the last tick and the output
//   valid, and loads the register defaults. The result sits in an output
//   register; a new sample is taken while it waits, and the sequencer only
//   holds in its last step if the previous result is still not taken.
// ---------------------------------------------------------------------------
module gyro_heading_integrator_unit #(
  parameter int FRACTION_BITS = ghi_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // tick [31:0], rate_word [47:32], angle_word [63:48], temperature_word [79:64]
  input  logic [ghi_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // rate_out [14:0], device_angle [28:15], temperature_q8 [46:29],
  // heading_q8 [69:47], zero [71:70]
  output logic [ghi_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ghi_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ghi_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ghi_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int DELTA_W    = FRACTION_BITS + 16;
  localparam int BIAS_SHIFT = ghi_pkg::BIAS_FRAC - FRACTION_BITS;
  localparam int HEAD_SHIFT = FRACTION_BITS + ghi_pkg::HEAD_SHIFT_EXTRA;

  typedef enum logic [3:0] {
    S_IDLE, S_BIAS, S_DELTA, S_DEAD, S_SUM, S_WRAP, S_MULH, S_MULL, S_FIN
  } state_t;

  state_t state_r;

  // registers
  logic signed [ghi_pkg::INIT_TEMP_W-1:0] init_temp_r;
  logic [ghi_pkg::BIAS_COEF_W-1:0]        bias_coef_r;
  logic [ghi_pkg::DEADBAND_W-1:0]         deadband_r;
  logic [ghi_pkg::WRAP_W-1:0]             wrap_r;
  logic [ghi_pkg::SCALE_W-1:0]            scale_r;
  logic [ghi_pkg::MIN_INT_W-1:0]          min_int_r;

  // sample and datapath
  logic [ghi_pkg::TICK_W-1:0]         last_tick_r;
  logic [ghi_pkg::ACC_W-1:0]          acc_r;
  logic signed [ghi_pkg::RATE_W-1:0]  rate_r;
  logic [ghi_pkg::ANGLE_W-1:0]        angle_r;
  logic signed [ghi_pkg::TEMP_W-1:0]  temp_r;
  logic signed [ghi_pkg::PROD_W-1:0]  prod_r;
  logic [ghi_pkg::PART_W-1:0]         hi_r;
  logic signed [DELTA_W-1:0]          delta_r;
  logic signed [ghi_pkg::SUM_W-1:0]   sum_r;
  logic signed [ghi_pkg::TQ8_W-1:0]   tq8_r;
  logic                               out_valid_r;
  logic [ghi_pkg::OUT_TDATA_W-1:0]    out_tdata_r;

  // ---------------------------------------------------------------- config
  logic                          cfg_wr;
  logic [ghi_pkg::REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[ghi_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_temp_r <= ghi_pkg::INIT_TEMP_RST;
      bias_coef_r <= ghi_pkg::BIAS_COEF_RST;
      deadband_r  <= ghi_pkg::DEADBAND_RST;
      wrap_r      <= ghi_pkg::WRAP_RST;
      scale_r     <= ghi_pkg::SCALE_RST;
      min_int_r   <= ghi_pkg::MIN_INT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ghi_pkg::REG_INIT_TEMP: init_temp_r <= pwdata[ghi_pkg::INIT_TEMP_W-1:0];
        ghi_pkg::REG_BIAS_COEF: bias_coef_r <= pwdata[ghi_pkg::BIAS_COEF_W-1:0];
        ghi_pkg::REG_DEADBAND:  deadband_r  <= pwdata[ghi_pkg::DEADBAND_W-1:0];
        ghi_pkg::REG_WRAP:      wrap_r      <= pwdata[ghi_pkg::WRAP_W-1:0];
        ghi_pkg::REG_SCALE:     scale_r     <= pwdata[ghi_pkg::SCALE_W-1:0];
        ghi_pkg::REG_MIN_INT:   min_int_r   <= pwdata[ghi_pkg::MIN_INT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ghi_pkg::REG_INIT_TEMP: prdata = ghi_pkg::CFG_DATA_W'(unsigned'(init_temp_r));
      ghi_pkg::REG_BIAS_COEF: prdata = ghi_pkg::CFG_DATA_W'(bias_coef_r);
      ghi_pkg::REG_DEADBAND:  prdata = ghi_pkg::CFG_DATA_W'(deadband_r);
      ghi_pkg::REG_WRAP:      prdata = ghi_pkg::CFG_DATA_W'(wrap_r);
      ghi_pkg::REG_SCALE:     prdata = ghi_pkg::CFG_DATA_W'(scale_r);
      ghi_pkg::REG_MIN_INT:   prdata = ghi_pkg::CFG_DATA_W'(min_int_r);
      default:                prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ input side
  logic [ghi_pkg::TICK_W-1:0] in_tick;
  logic [ghi_pkg::TICK_W-1:0] tick_diff;
  logic                       in_fire;
  logic                       take;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign in_tick   = in_tdata[ghi_pkg::TICK_LSB +: ghi_pkg::TICK_W];
  assign tick_diff = in_tick - last_tick_r;
  assign take      = tick_diff >= ghi_pkg::TICK_W'(min_int_r);

  // ------------------------------------------------------ shared multiplier
  logic signed [ghi_pkg::TDIFF_W-1:0] temp_diff;
  logic signed [ghi_pkg::MA_W-1:0]    mul_a;
  logic signed [ghi_pkg::MB_W-1:0]    mul_b;
  logic signed [ghi_pkg::PROD_W-1:0]  mul_p;

  assign temp_diff = ghi_pkg::TDIFF_W'(temp_r) - ghi_pkg::TDIFF_W'(init_temp_r);

  always_comb begin
    unique case (state_r)
      S_BIAS: begin
        mul_a = ghi_pkg::MA_W'(temp_diff);
        mul_b = $signed({1'b0, bias_coef_r});
      end
      S_DELTA: begin
        mul_a = ghi_pkg::MA_W'(temp_r);
        mul_b = $signed(ghi_pkg::TEMP_SCALE);
      end
      S_MULH: begin
        mul_a = $signed({1'b0, acc_r});
        mul_b = $signed(ghi_pkg::MB_W'(scale_r[ghi_pkg::SCALE_W-1:ghi_pkg::SCALE_SPLIT]));
      end
      S_MULL: begin
        mul_a = $signed({1'b0, acc_r});
        mul_b = $signed(ghi_pkg::MB_W'(scale_r[ghi_pkg::SCALE_SPLIT-1:0]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ------------------------------------------------------------- datapath
  logic signed [ghi_pkg::BIAS_W-1:0]  bias_q;
  logic signed [DELTA_W-1:0]          delta_nxt;
  logic signed [DELTA_W-1:0]          thr;
  logic                               in_band;
  logic signed [ghi_pkg::TPROD_W-1:0] tprod_sh;
  logic signed [ghi_pkg::TQ8_W-1:0]   tq8_nxt;
  logic signed [ghi_pkg::SUM_W-1:0]   sum_nxt;
  logic signed [ghi_pkg::SUM_W-1:0]   span;
  logic signed [ghi_pkg::SUM_W-1:0]   wrapped;
  logic [ghi_pkg::TOTAL_W-1:0]        total;
  logic [ghi_pkg::TOTAL_W-1:0]        head_full;
  logic [ghi_pkg::HEAD_W-1:0]         head_sat;
  logic signed [ghi_pkg::RATE_OUT_W-1:0] rate_neg;

  // floor shift of the Q24 bias down to the working fraction
  assign bias_q    = $signed(prod_r[ghi_pkg::BIAS_W-1:0]) >>> BIAS_SHIFT;
  assign delta_nxt = (DELTA_W'(rate_r) <<< FRACTION_BITS) - DELTA_W'(bias_q);

  assign thr     = $signed(DELTA_W'({deadband_r, {FRACTION_BITS{1'b0}}}));
  assign in_band = (delta_r < thr) && (delta_r > -thr);

  assign tprod_sh = $signed(prod_r[ghi_pkg::TPROD_W-1:0]) >>> ghi_pkg::TEMP_SHIFT;
  assign tq8_nxt  = ghi_pkg::TQ8_W'(tprod_sh) + $signed(ghi_pkg::TEMP_OFFSET);

  assign sum_nxt = $signed(ghi_pkg::SUM_W'(acc_r)) + ghi_pkg::SUM_W'(delta_r);
  assign span    = $signed(ghi_pkg::SUM_W'({wrap_r, {FRACTION_BITS{1'b0}}}));

  // single correction step into [0, span)
  always_comb begin
    if (sum_r < 0) begin
      wrapped = sum_r + span;
    end else if (sum_r >= span) begin
      wrapped = sum_r - span;
    end else begin
      wrapped = sum_r;
    end
  end

  assign total     = ghi_pkg::TOTAL_W'(hi_r)
                   + ghi_pkg::TOTAL_W'(prod_r[ghi_pkg::PART_W-1:ghi_pkg::SCALE_SPLIT]);
  assign head_full = total >> HEAD_SHIFT;
  assign head_sat  = (|head_full[ghi_pkg::TOTAL_W-1:ghi_pkg::HEAD_W]) ? ghi_pkg::HEAD_MAX
                                                                     : head_full[ghi_pkg::HEAD_W-1:0];
  assign rate_neg  = -ghi_pkg::RATE_OUT_W'(rate_r);

  // ------------------------------------------------------------ sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_tick_r <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the last step reloads the valid itself
      if (out_valid_r && out_tready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && take) begin
            last_tick_r <= in_tick;
            rate_r      <= in_tdata[ghi_pkg::RATE_LSB +: ghi_pkg::RATE_W];
            angle_r     <= in_tdata[ghi_pkg::ANGLE_LSB +: ghi_pkg::ANGLE_W];
            temp_r      <= in_tdata[ghi_pkg::TEMP_LSB +: ghi_pkg::TEMP_W];
            state_r     <= S_BIAS;
          end
        end
        S_BIAS: begin
          prod_r  <= mul_p;
          state_r <= S_DELTA;
        end
        S_DELTA: begin
          delta_r <= delta_nxt;
          prod_r  <= mul_p;
          state_r <= S_DEAD;
        end
        S_DEAD: begin
          if (in_band) begin
            delta_r <= '0;
          end
          tq8_r   <= tq8_nxt;
          state_r <= S_SUM;
        end
        S_SUM: begin
          sum_r   <= sum_nxt;
          state_r <= S_WRAP;
        end
        S_WRAP: begin
          acc_r   <= wrapped[ghi_pkg::ACC_W-1:0];
          state_r <= S_MULH;
        end
        S_MULH: begin
          prod_r  <= mul_p;
          state_r <= S_MULL;
        end
        S_MULL: begin
          hi_r    <= prod_r[ghi_pkg::PART_W-1:0];
          prod_r  <= mul_p;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_tdata_r <= {{ghi_pkg::OUT_PAD_W{1'b0}}, head_sat, tq8_r, angle_r, rate_neg};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ----- rtl/ghi_checker.sv -----
// ---------------------------------------------------------------------------
// ghi_checker
// Port-level checks on the gyro heading integrator, bound to the top level.
// ---------------------------------------------------------------------------
module ghi_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic [ghi_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic                            pready
);

  localparam int TQ8_LSB  = ghi_pkg::RATE_OUT_W + ghi_pkg::ANGLE_W;
  localparam int PAD_LSB  = TQ8_LSB + ghi_pkg::TQ8_W + ghi_pkg::HEAD_W;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  // reset drops any pending result
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid survived reset");

  // padding above the heading stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ghi_pkg::OUT_TDATA_W-1:PAD_LSB] == '0)
    else $error("output padding not zero");

  // temperature stays inside what a 12-bit reading can give
  a_tq8_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      $signed(out_tdata[TQ8_LSB +: ghi_pkg::TQ8_W]) >= -18'sd69776 &&
      $signed(out_tdata[TQ8_LSB +: ghi_pkg::TQ8_W]) <= 18'sd82540)
    else $error("temperature out of range");

  // negated 14-bit rate can never be -8192, the most negative 14-bit code
  a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && pready |->
      out_tdata[ghi_pkg::RATE_OUT_W-1:0] != ghi_pkg::RATE_OUT_W'(15'h6000))
    else $error("negated rate out of range");

endmodule

bind gyro_heading_integrator_unit ghi_checker u_ghi_checker (.*);
